>>> hdl/traffic_lamp_sequencer_top_macros.svh
// assertion macros used by the traffic lamp sequencer top level
`ifndef TRAFFIC_LAMP_SEQUENCER_TOP_MACROS_SVH
`define TRAFFIC_LAMP_SEQUENCER_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define TLS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define TLS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/tls_pkg.sv
// types, codes and helpers for the traffic lamp sequencer
package tls_pkg;

    localparam int DUR_W     = 16;
    localparam int CODE_W    = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_RED_DURATION    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AMBER_DURATION  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_DURATION  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_FREQUENCY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STRAIGHT_ONLY   = 3'd4;

    // external state codes, shared by command_state and present_state
    localparam logic [CODE_W-1:0] CODE_OFF         = 3'd0;
    localparam logic [CODE_W-1:0] CODE_AUTO_RED    = 3'd1;
    localparam logic [CODE_W-1:0] CODE_AUTO_AMBER  = 3'd2;
    localparam logic [CODE_W-1:0] CODE_AUTO_GREEN  = 3'd3;
    localparam logic [CODE_W-1:0] CODE_DICT_RED    = 3'd4;
    localparam logic [CODE_W-1:0] CODE_DICT_AMBER  = 3'd5;
    localparam logic [CODE_W-1:0] CODE_DICT_GREEN  = 3'd6;
    localparam logic [CODE_W-1:0] CODE_BLINK       = 3'd7;

    // distance between an auto colour and its dictated copy
    localparam logic [CODE_W-1:0] DICT_OFFSET = 3'd3;

    localparam logic KIND_TICK    = 1'b0;
    localparam logic KIND_COMMAND = 1'b1;

    typedef enum logic [7:0] {
        PH_OFF        = 8'b0000_0001,
        PH_AUTO_RED   = 8'b0000_0010,
        PH_AUTO_AMBER = 8'b0000_0100,
        PH_AUTO_GREEN = 8'b0000_1000,
        PH_DICT_RED   = 8'b0001_0000,
        PH_DICT_AMBER = 8'b0010_0000,
        PH_DICT_GREEN = 8'b0100_0000,
        PH_BLINK      = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        logic              kind;
        logic              dictated_control;
        logic [CODE_W-1:0] command_state;
    } t_item;

    typedef struct packed {
        logic              lamp_red;
        logic              lamp_amber;
        logic              arrow_forward;
        logic              arrow_left;
        logic              arrow_right;
        logic              blink_active;
        logic [CODE_W-1:0] present_state;
        logic [DUR_W-1:0]  time_remaining;
    } t_result;

    typedef struct packed {
        logic [DUR_W-1:0] red_duration;
        logic [DUR_W-1:0] amber_duration;
        logic [DUR_W-1:0] green_duration;
        logic             straight_only;
    } t_cfg;

    function automatic t_phase code_to_phase(input logic [CODE_W-1:0] code);
        t_phase ph;
        unique case (code)
            CODE_OFF:        ph = PH_OFF;
            CODE_AUTO_RED:   ph = PH_AUTO_RED;
            CODE_AUTO_AMBER: ph = PH_AUTO_AMBER;
            CODE_AUTO_GREEN: ph = PH_AUTO_GREEN;
            CODE_DICT_RED:   ph = PH_DICT_RED;
            CODE_DICT_AMBER: ph = PH_DICT_AMBER;
            CODE_DICT_GREEN: ph = PH_DICT_GREEN;
            CODE_BLINK:      ph = PH_BLINK;
            default:         ph = PH_OFF;
        endcase
        return ph;
    endfunction

    function automatic logic [CODE_W-1:0] phase_to_code(input t_phase ph);
        logic [CODE_W-1:0] code;
        unique case (ph)
            PH_OFF:        code = CODE_OFF;
            PH_AUTO_RED:   code = CODE_AUTO_RED;
            PH_AUTO_AMBER: code = CODE_AUTO_AMBER;
            PH_AUTO_GREEN: code = CODE_AUTO_GREEN;
            PH_DICT_RED:   code = CODE_DICT_RED;
            PH_DICT_AMBER: code = CODE_DICT_AMBER;
            PH_DICT_GREEN: code = CODE_DICT_GREEN;
            PH_BLINK:      code = CODE_BLINK;
            default:       code = CODE_OFF;
        endcase
        return code;
    endfunction

    function automatic logic is_auto_code(input logic [CODE_W-1:0] code);
        return (code == CODE_AUTO_RED) || (code == CODE_AUTO_AMBER) ||
               (code == CODE_AUTO_GREEN);
    endfunction

endpackage

>>> hdl/tls_cfg.sv
// configuration register file of the traffic lamp sequencer
module tls_cfg
    import tls_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_wdata,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_RED_DURATION:    r_cfg.red_duration   <= i_cfg_wdata[DUR_W-1:0];
                REG_AMBER_DURATION:  r_cfg.amber_duration <= i_cfg_wdata[DUR_W-1:0];
                REG_GREEN_DURATION:  r_cfg.green_duration <= i_cfg_wdata[DUR_W-1:0];
                // blink tone is generated off-block, nothing kept here
                REG_BLINK_FREQUENCY: r_cfg <= r_cfg;
                REG_STRAIGHT_ONLY:   r_cfg.straight_only  <= i_cfg_wdata[0];
                default:             r_cfg <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> hdl/tls_core.sv
// phase state, tick counter and transition rules of the traffic lamp sequencer
module tls_core
    import tls_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    t_phase            r_phase;
    logic [CODE_W-1:0] r_req;
    logic [DUR_W-1:0]  r_elapsed;

    t_phase            n_phase;
    logic [CODE_W-1:0] n_req;
    logic [DUR_W-1:0]  n_elapsed;

    logic [CODE_W-1:0] cur_code;
    logic [CODE_W-1:0] target;
    logic              do_enter;
    logic [DUR_W-1:0]  elapsed_inc;
    logic [DUR_W-1:0]  cur_dur;
    logic [DUR_W-1:0]  new_dur;
    logic [CODE_W-1:0] new_code;

    function automatic logic [DUR_W-1:0] dur_of(input t_phase ph, input t_cfg cfg);
        logic [DUR_W-1:0] d;
        unique case (ph) inside
            PH_AUTO_RED:   d = cfg.red_duration;
            PH_AUTO_AMBER: d = cfg.amber_duration;
            PH_AUTO_GREEN: d = cfg.green_duration;
            default:       d = '0;
        endcase
        return d;
    endfunction

    assign cur_code    = phase_to_code(r_phase);
    assign cur_dur     = dur_of(r_phase, i_cfg);
    assign elapsed_inc = (r_elapsed == {DUR_W{1'b1}}) ? r_elapsed : r_elapsed + 1'b1;

    always_comb begin
        n_phase   = r_phase;
        n_req     = r_req;
        n_elapsed = r_elapsed;
        target    = cur_code;
        do_enter  = 1'b0;
        if (i_fire) begin
            if (i_item.kind == KIND_COMMAND) begin
                n_req = i_item.command_state;
            end else begin
                n_elapsed = elapsed_inc;
                unique case (r_phase) inside
                    PH_OFF: begin
                        if (r_req != CODE_OFF) begin
                            target   = r_req;
                            do_enter = 1'b1;
                        end
                    end
                    PH_AUTO_RED, PH_AUTO_AMBER, PH_AUTO_GREEN: begin
                        if (i_item.dictated_control) begin
                            target   = cur_code + DICT_OFFSET;
                            n_req    = cur_code + DICT_OFFSET;
                            do_enter = 1'b1;
                        end else if (r_req == CODE_BLINK) begin
                            target   = CODE_BLINK;
                            do_enter = 1'b1;
                        end else if (elapsed_inc >= cur_dur) begin
                            target   = (r_phase == PH_AUTO_GREEN) ? CODE_AUTO_RED
                                                                  : cur_code + 1'b1;
                            do_enter = 1'b1;
                        end
                    end
                    PH_DICT_RED, PH_DICT_AMBER, PH_DICT_GREEN: begin
                        if (!i_item.dictated_control) begin
                            target   = cur_code - DICT_OFFSET;
                            n_req    = cur_code - DICT_OFFSET;
                            do_enter = 1'b1;
                        end else if (r_req != cur_code && r_req >= CODE_DICT_RED) begin
                            target   = r_req;
                            do_enter = 1'b1;
                        end
                    end
                    PH_BLINK: begin
                        if (r_req == CODE_DICT_RED) begin
                            target   = CODE_DICT_RED;
                            do_enter = 1'b1;
                        end
                    end
                    default: begin
                        do_enter = 1'b0;
                    end
                endcase
                if (do_enter) begin
                    n_phase = code_to_phase(target);
                    // counter restarts on entry to any auto colour
                    if (is_auto_code(target)) begin
                        n_elapsed = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_OFF;
            r_req     <= CODE_OFF;
            r_elapsed <= '0;
        end else begin
            r_phase   <= n_phase;
            r_req     <= n_req;
            r_elapsed <= n_elapsed;
        end
    end

    // result reflects the state after this request
    assign new_code = phase_to_code(n_phase);
    assign new_dur  = dur_of(n_phase, i_cfg);

    always_comb begin
        o_result                = '0;
        o_result.present_state  = new_code;
        o_result.lamp_red       = (n_phase == PH_AUTO_RED)   || (n_phase == PH_DICT_RED);
        o_result.lamp_amber     = (n_phase == PH_AUTO_AMBER) || (n_phase == PH_DICT_AMBER);
        o_result.arrow_forward  = (n_phase == PH_AUTO_GREEN) || (n_phase == PH_DICT_GREEN);
        o_result.arrow_left     = o_result.arrow_forward && !i_cfg.straight_only;
        o_result.arrow_right    = o_result.arrow_forward && !i_cfg.straight_only;
        o_result.blink_active   = (n_phase == PH_BLINK);
        if (is_auto_code(new_code) && (new_dur > n_elapsed)) begin
            o_result.time_remaining = new_dur - n_elapsed;
        end
    end

endmodule

>>> hdl/traffic_lamp_sequencer_top.sv
// top level of the traffic lamp sequencer: request and result registers
//
//  channel   direction  handshake                       payload
//  in        request    i_in_valid / o_in_stall         i_in_data  (t_item)
//  out       result     o_out_valid / i_out_stall       o_out_data (t_result)
//  cfg       write      i_cfg_we                        i_cfg_idx, i_cfg_wdata
//
// one request per cycle sustained while the result is not stalled; each result passes
// through the request register, then the single-pass transition logic into the result
// register, before it is presented
// reset is synchronous and active low, state returns to off with cleared durations
// a stalled result holds the request register, and the input stalls only once both
// registers are full
`include "traffic_lamp_sequencer_top_macros.svh"

module traffic_lamp_sequencer_top
    import tls_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_item                i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_result              o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_wdata
);

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;

    logic    in_accept;
    logic    advance;
    t_cfg    cfg;
    t_result result;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    tls_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    tls_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `TLS_ASSERT_NOW(a_stall_needs_full, o_in_stall, r_in_valid,
        "input stalled with empty request register")
    `TLS_ASSERT_NOW(a_one_lamp, o_out_valid,
        $onehot0({o_out_data.lamp_red, o_out_data.lamp_amber,
                  o_out_data.arrow_forward, o_out_data.blink_active}),
        "more than one lamp group lit")
    `TLS_ASSERT_NOW(a_side_with_fwd,
        o_out_valid && (o_out_data.arrow_left || o_out_data.arrow_right),
        o_out_data.arrow_forward, "side arrow lit without forward")
    `TLS_ASSERT_NOW(a_remain_auto_only,
        o_out_valid && (o_out_data.time_remaining != '0),
        (o_out_data.present_state == CODE_AUTO_RED) ||
        (o_out_data.present_state == CODE_AUTO_AMBER) ||
        (o_out_data.present_state == CODE_AUTO_GREEN),
        "time remaining outside an auto state")
    `TLS_ASSERT_NEXT(a_advance_fills_out, advance, r_out_valid,
        "advanced request gave no result")

endmodule

>>> dv/tb_top.sv
// self-checking testbench for the traffic lamp sequencer top level
`timescale 1ns / 1ps

module tb_top;
    import tls_pkg::*;

    localparam int QUIET_LIMIT   = 1000;
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_WAIT      = 16;
    localparam int PRINT_LIMIT   = 40;
    localparam int RANDOM_ITEMS  = 360;
    localparam int LONG_TICKS    = 200;
    localparam logic [DUR_W-1:0] DUR_MAX = '1;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_item                i_in_data;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_result              o_out_data;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DAT_W-1:0] i_cfg_wdata;

    traffic_lamp_sequencer_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // lamp head copy kept in step with the requests the block accepts
    t_cfg              cfg_now     = '0;
    logic [CODE_W-1:0] lamp_now    = CODE_OFF;
    logic [CODE_W-1:0] lamp_want   = CODE_OFF;
    logic [DUR_W-1:0]  ticks_seen  = '0;

    t_item   pending_requests[$];
    t_result expected_status[$];

    int  mismatches = 0;
    int  quiet      = 0;
    bit  req_taken  = 1'b0;
    bit  res_taken  = 1'b0;
    bit  in_busy    = 1'b0;
    int  in_gap     = 0;
    int  out_hold   = 0;
    bit  calm       = 1'b0;
    bit  hurry      = 1'b0;
    bit  dict_mode  = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic bit auto_colour(input logic [CODE_W-1:0] code);
        return code >= CODE_AUTO_RED && code <= CODE_AUTO_GREEN;
    endfunction

    function automatic logic [DUR_W-1:0] span_of(input logic [CODE_W-1:0] code);
        case (code)
            CODE_AUTO_RED:   return cfg_now.red_duration;
            CODE_AUTO_AMBER: return cfg_now.amber_duration;
            CODE_AUTO_GREEN: return cfg_now.green_duration;
            default:         return '0;
        endcase
    endfunction

    function automatic logic [CODE_W-1:0] next_colour(input logic [CODE_W-1:0] code);
        case (code)
            CODE_AUTO_RED:   return CODE_AUTO_AMBER;
            CODE_AUTO_AMBER: return CODE_AUTO_GREEN;
            default:         return CODE_AUTO_RED;
        endcase
    endfunction

    function automatic void move_to(input logic [CODE_W-1:0] code);
        lamp_now = code;
        if (auto_colour(code))
            ticks_seen = '0;
    endfunction

    // apply one request to the lamp copy and return the status it should show
    function automatic t_result step_lamp(input t_item rq);
        t_result          r;
        logic [DUR_W-1:0] span;
        if (rq.kind == KIND_COMMAND) begin
            lamp_want = rq.command_state;
        end else begin
            if (ticks_seen != DUR_MAX)
                ticks_seen = ticks_seen + 1'b1;
            if (lamp_now == CODE_OFF) begin
                if (lamp_want != CODE_OFF)
                    move_to(lamp_want);
            end else if (auto_colour(lamp_now)) begin
                if (rq.dictated_control) begin
                    // forced moves overwrite the pending command
                    lamp_want = lamp_now + DICT_OFFSET;
                    move_to(lamp_want);
                end else if (lamp_want == CODE_BLINK) begin
                    move_to(CODE_BLINK);
                end else if (ticks_seen >= span_of(lamp_now)) begin
                    move_to(next_colour(lamp_now));
                end
            end else if (lamp_now != CODE_BLINK) begin
                if (!rq.dictated_control) begin
                    lamp_want = lamp_now - DICT_OFFSET;
                    move_to(lamp_want);
                end else if (lamp_want != lamp_now && lamp_want >= CODE_DICT_RED) begin
                    move_to(lamp_want);
                end
            end else if (lamp_want == CODE_DICT_RED) begin
                move_to(CODE_DICT_RED);
            end
        end

        r = '0;
        r.present_state = lamp_now;
        case (lamp_now)
            CODE_AUTO_RED, CODE_DICT_RED:     r.lamp_red = 1'b1;
            CODE_AUTO_AMBER, CODE_DICT_AMBER: r.lamp_amber = 1'b1;
            CODE_AUTO_GREEN, CODE_DICT_GREEN: begin
                r.arrow_forward = 1'b1;
                r.arrow_left    = !cfg_now.straight_only;
                r.arrow_right   = !cfg_now.straight_only;
            end
            CODE_BLINK:                       r.blink_active = 1'b1;
            default: ;
        endcase
        span = span_of(lamp_now);
        if (auto_colour(lamp_now) && span > ticks_seen)
            r.time_remaining = span - ticks_seen;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    endtask

    function automatic int draw_wait();
        if ($urandom_range(0, 40) == 0)
            calm = !calm;
        if (hurry || calm)
            return 0;
        return int'($urandom_range(0, MAX_WAIT));
    endfunction

    function automatic t_item lamp_request(input logic kind, input logic dict,
                                           input logic [CODE_W-1:0] code);
        t_item rq;
        rq.kind             = kind;
        rq.dictated_control = dict;
        rq.command_state    = code;
        return rq;
    endfunction

    // mostly ticks under a sticky control mode, with commands mixed in
    function automatic t_item random_request();
        t_item rq;
        rq.command_state    = CODE_W'($urandom_range(0, 7));
        rq.dictated_control = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 4) == 0) begin
            rq.kind = KIND_COMMAND;
        end else begin
            rq.kind = KIND_TICK;
            if ($urandom_range(0, 11) == 0)
                dict_mode = !dict_mode;
            rq.dictated_control = dict_mode;
        end
        return rq;
    endfunction

    // request driver
    always @(negedge i_clk) begin
        t_item nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (req_taken)
                in_busy = 1'b0;
            if (!in_busy) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    nxt = pending_requests.pop_front();
                    i_in_data  <= nxt;
                    i_in_valid <= 1'b1;
                    in_busy = 1'b1;
                    in_gap  = draw_wait();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result stall
    always @(negedge i_clk) begin
        if (res_taken)
            out_hold = draw_wait();
        if (out_hold > 0) begin
            out_hold--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // monitor: register writes, accepted requests and results
    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        req_taken <= i_in_valid && !o_in_stall;
        res_taken <= o_out_valid && !i_out_stall;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_RED_DURATION:    cfg_now.red_duration   = i_cfg_wdata;
                    REG_AMBER_DURATION:  cfg_now.amber_duration = i_cfg_wdata;
                    REG_GREEN_DURATION:  cfg_now.green_duration = i_cfg_wdata;
                    REG_STRAIGHT_ONLY:   cfg_now.straight_only  = i_cfg_wdata[0];
                    // blink tone has no effect on the status
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall)
                expected_status.push_back(step_lamp(i_in_data));
            if (o_out_valid && !i_out_stall) begin
                if (expected_status.size() == 0) begin
                    report_mismatch("result with nothing pending", 0, 0);
                end else begin
                    want = expected_status.pop_front();
                    got  = o_out_data;
                    if (got.lamp_red !== want.lamp_red)
                        report_mismatch("lamp_red", int'(got.lamp_red),
                                        int'(want.lamp_red));
                    if (got.lamp_amber !== want.lamp_amber)
                        report_mismatch("lamp_amber", int'(got.lamp_amber),
                                        int'(want.lamp_amber));
                    if (got.arrow_forward !== want.arrow_forward)
                        report_mismatch("arrow_forward", int'(got.arrow_forward),
                                        int'(want.arrow_forward));
                    if (got.arrow_left !== want.arrow_left)
                        report_mismatch("arrow_left", int'(got.arrow_left),
                                        int'(want.arrow_left));
                    if (got.arrow_right !== want.arrow_right)
                        report_mismatch("arrow_right", int'(got.arrow_right),
                                        int'(want.arrow_right));
                    if (got.blink_active !== want.blink_active)
                        report_mismatch("blink_active", int'(got.blink_active),
                                        int'(want.blink_active));
                    if (got.present_state !== want.present_state)
                        report_mismatch("present_state", int'(got.present_state),
                                        int'(want.present_state));
                    if (got.time_remaining !== want.time_remaining)
                        report_mismatch("time_remaining", int'(got.time_remaining),
                                        int'(want.time_remaining));
                end
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet <= 0;
            end else if (quiet >= QUIET_LIMIT) begin
                $display("FAIL traffic_lamp_sequencer_top");
                $finish;
            end else begin
                quiet <= quiet + 1;
            end
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
    endtask

    task automatic cfg_done();
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_requests.size() != 0 || i_in_valid || expected_status.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_stall = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_wdata = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: every duration zero, so auto colours last one tick
        pending_requests.push_back(lamp_request(KIND_TICK, 1'b0, CODE_BLINK));
        pending_requests.push_back(lamp_request(KIND_COMMAND, 1'b1, CODE_AUTO_RED));
        repeat (4) pending_requests.push_back(lamp_request(KIND_TICK, 1'b0, CODE_OFF));
        pending_requests.push_back(lamp_request(KIND_COMMAND, 1'b0, CODE_BLINK));
        pending_requests.push_back(lamp_request(KIND_TICK, 1'b0, CODE_DICT_GREEN));
        // blinker ignores everything but dictated red
        pending_requests.push_back(lamp_request(KIND_COMMAND, 1'b0, CODE_AUTO_GREEN));
        pending_requests.push_back(lamp_request(KIND_TICK, 1'b0, CODE_OFF));
        pending_requests.push_back(lamp_request(KIND_COMMAND, 1'b1, CODE_DICT_AMBER));
        pending_requests.push_back(lamp_request(KIND_TICK, 1'b1, CODE_OFF));
        pending_requests.push_back(lamp_request(KIND_COMMAND, 1'b0, CODE_DICT_RED));
        pending_requests.push_back(lamp_request(KIND_TICK, 1'b1, CODE_OFF));
        pending_requests.push_back(lamp_request(KIND_COMMAND, 1'b0, CODE_DICT_GREEN));
        pending_requests.push_back(lamp_request(KIND_TICK, 1'b1, CODE_AUTO_AMBER));
        // same state again, then off, both ignored
        pending_requests.push_back(lamp_request(KIND_TICK, 1'b1, CODE_OFF));
        pending_requests.push_back(lamp_request(KIND_COMMAND, 1'b1, CODE_OFF));
        pending_requests.push_back(lamp_request(KIND_TICK, 1'b1, CODE_BLINK));
        // control mode forces auto and dictated copies
        pending_requests.push_back(lamp_request(KIND_TICK, 1'b0, CODE_OFF));
        pending_requests.push_back(lamp_request(KIND_TICK, 1'b1, CODE_OFF));
        pending_requests.push_back(lamp_request(KIND_COMMAND, 1'b0, CODE_BLINK));
        pending_requests.push_back(lamp_request(KIND_TICK, 1'b1, CODE_OFF));
        pending_requests.push_back(lamp_request(KIND_COMMAND, 1'b1, CODE_DICT_RED));
        pending_requests.push_back(lamp_request(KIND_TICK, 1'b0, CODE_OFF));
        pending_requests.push_back(lamp_request(KIND_TICK, 1'b0, CODE_OFF));
        drain();

        cfg_write(REG_RED_DURATION, CFG_DAT_W'($urandom_range(1, 4)));
        cfg_write(REG_AMBER_DURATION, CFG_DAT_W'($urandom_range(0, 3)));
        cfg_write(REG_GREEN_DURATION, CFG_DAT_W'($urandom_range(1, 4)));
        cfg_write(REG_BLINK_FREQUENCY, CFG_DAT_W'($urandom));
        cfg_write(REG_STRAIGHT_ONLY, '0);
        cfg_done();
        repeat (RANDOM_ITEMS) pending_requests.push_back(random_request());
        drain();

        // only bit 0 of the straight_only write matters
        cfg_write(REG_RED_DURATION, CFG_DAT_W'($urandom_range(1, 8)));
        cfg_write(REG_AMBER_DURATION, CFG_DAT_W'($urandom_range(1, 8)));
        cfg_write(REG_GREEN_DURATION, CFG_DAT_W'($urandom_range(1, 8)));
        cfg_write(REG_STRAIGHT_ONLY, CFG_DAT_W'($urandom | 1));
        cfg_done();
        repeat (RANDOM_ITEMS) pending_requests.push_back(random_request());
        drain();

        cfg_write(REG_RED_DURATION, '0);
        cfg_write(REG_AMBER_DURATION, '0);
        cfg_write(REG_GREEN_DURATION, '0);
        cfg_write(REG_BLINK_FREQUENCY, '0);
        cfg_write(REG_STRAIGHT_ONLY, 16'hFFFE);
        // indexes past the last register must not disturb anything
        for (int k = REG_STRAIGHT_ONLY + 1; k < (1 << CFG_IDX_W); k++)
            cfg_write(CFG_IDX_W'(k), CFG_DAT_W'($urandom));
        cfg_done();
        repeat (RANDOM_ITEMS) pending_requests.push_back(random_request());
        drain();

        // longest durations: auto red counts down from the top of the range
        cfg_write(REG_RED_DURATION, DUR_MAX);
        cfg_write(REG_AMBER_DURATION, DUR_MAX);
        cfg_write(REG_GREEN_DURATION, DUR_MAX);
        cfg_write(REG_BLINK_FREQUENCY, DUR_MAX);
        cfg_write(REG_STRAIGHT_ONLY, DUR_MAX);
        cfg_done();
        hurry = 1'b1;
        repeat (3) begin
            pending_requests.push_back(lamp_request(KIND_COMMAND, 1'b0, CODE_DICT_RED));
            pending_requests.push_back(lamp_request(KIND_TICK, 1'b1, CODE_OFF));
        end
        pending_requests.push_back(lamp_request(KIND_TICK, 1'b0, CODE_OFF));
        repeat (LONG_TICKS)
            pending_requests.push_back(lamp_request(KIND_TICK, 1'b0,
                                                    CODE_W'($urandom_range(0, 7))));
        drain();
        hurry = 1'b0;
        repeat (40) pending_requests.push_back(random_request());
        drain();

        if (mismatches == 0)
            $display("PASS traffic_lamp_sequencer_top");
        else
            $display("FAIL traffic_lamp_sequencer_top");
        $finish;
    end

endmodule
